@@ rtl/ddlr_pkg.sv @@
// ----------------------------------------------------------------------------
// ddlr_pkg
// Shared types, codes and the control program of the dirty-line refresh engine.
// ----------------------------------------------------------------------------
package ddlr_pkg;

   // Configuration register indexes.
   localparam logic CSR_BUFFER_LINES  = 1'b0;
   localparam logic CSR_COLUMN_OFFSET = 1'b1;

   // Display command bytes.
   localparam logic [7:0] CMD_LOW_COL  = 8'h00;
   localparam logic [7:0] CMD_HIGH_COL = 8'h10;
   localparam logic [7:0] CMD_PAGE     = 8'hB0;

   // Result kinds.
   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_CMD    = 2'd1;
   localparam logic [1:0] KIND_DATA   = 2'd2;

   // Refresh sequencer states, as seen by the step items.
   localparam logic [2:0] SEQ_IDLE   = 3'd0;
   localparam logic [2:0] SEQ_FREE   = 3'd1;
   localparam logic [2:0] SEQ_HALF_B = 3'd2;
   localparam logic [2:0] SEQ_HALF_A = 3'd3;
   localparam logic [2:0] SEQ_PAGE   = 3'd4;
   localparam logic [2:0] SEQ_HIGH   = 3'd5;
   localparam logic [2:0] SEQ_LOW    = 3'd6;

   // Result selection of a control word.
   localparam logic [2:0] EM_NONE   = 3'd0;
   localparam logic [2:0] EM_STATUS = 3'd1;
   localparam logic [2:0] EM_FREE   = 3'd2;
   localparam logic [2:0] EM_LOW    = 3'd3;
   localparam logic [2:0] EM_HIGH   = 3'd4;
   localparam logic [2:0] EM_PAGE   = 3'd5;
   localparam logic [2:0] EM_DATA   = 3'd6;

   // Datapath operations.
   localparam logic [2:0] OP_NONE       = 3'd0;
   localparam logic [2:0] OP_CLEAR      = 3'd1;
   localparam logic [2:0] OP_FILL_SETUP = 3'd2;
   localparam logic [2:0] OP_FILL_WRITE = 3'd3;
   localparam logic [2:0] OP_LOAD_A     = 3'd4;
   localparam logic [2:0] OP_LOAD_B     = 3'd5;
   localparam logic [2:0] OP_SEND       = 3'd6;
   localparam logic [2:0] OP_SCAN       = 3'd7;

   // Branch kinds.
   localparam logic [1:0] BR_GOTO     = 2'd0;  // to target when the step fires
   localparam logic [1:0] BR_LOOP     = 2'd1;  // repeat until done, then target
   localparam logic [1:0] BR_COND     = 2'd2;  // done: target, else next step
   localparam logic [1:0] BR_DISPATCH = 2'd3;  // take an item and decode it

   // Program steps.
   localparam logic [3:0] U_CLEAR      = 4'd0;
   localparam logic [3:0] U_WAIT       = 4'd1;
   localparam logic [3:0] U_FILL_SETUP = 4'd2;
   localparam logic [3:0] U_FILL_WRITE = 4'd3;
   localparam logic [3:0] U_CMD_LOW    = 4'd4;
   localparam logic [3:0] U_CMD_HIGH   = 4'd5;
   localparam logic [3:0] U_CMD_PAGE   = 4'd6;
   localparam logic [3:0] U_HALF_A     = 4'd7;
   localparam logic [3:0] U_HALF_B     = 4'd8;
   localparam logic [3:0] U_SEND       = 4'd9;
   localparam logic [3:0] U_FREE       = 4'd10;
   localparam logic [3:0] U_SCAN       = 4'd11;

   typedef struct packed {
      logic       take;
      logic [2:0] emit;
      logic [2:0] op;
      logic       seq_ld;
      logic [2:0] seq_val;
      logic [1:0] br;
      logic [3:0] target;
   } uword_type;

   typedef struct packed {
      uword_type word;
      logic      fire;
   } ctrl_type;

   typedef struct packed {
      logic       done;
      logic       out_free;
      logic [2:0] seq_state;
   } stat_type;

   typedef struct packed {
      logic [3:0] buffer_lines;
      logic [3:0] column_offset;
   } cfg_type;

   // Control program.
   function automatic uword_type ucode(input logic [3:0] upc);
      uword_type w;
      w = '0;
      w.br = BR_GOTO;
      w.target = U_WAIT;
      case (upc)
         U_CLEAR: begin
            w.op = OP_CLEAR;
            w.br = BR_LOOP;
         end
         U_WAIT: begin
            w.take = 1'b1;
            w.br = BR_DISPATCH;
         end
         U_FILL_SETUP: begin
            w.op = OP_FILL_SETUP;
            w.br = BR_COND;
         end
         U_FILL_WRITE: begin
            w.op = OP_FILL_WRITE;
            w.br = BR_LOOP;
         end
         U_CMD_LOW: begin
            w.emit = EM_LOW;
            w.seq_ld = 1'b1;
            w.seq_val = SEQ_HIGH;
         end
         U_CMD_HIGH: begin
            w.emit = EM_HIGH;
            w.seq_ld = 1'b1;
            w.seq_val = SEQ_PAGE;
         end
         U_CMD_PAGE: begin
            w.emit = EM_PAGE;
            w.seq_ld = 1'b1;
            w.seq_val = SEQ_HALF_A;
         end
         U_HALF_A: begin
            w.op = OP_LOAD_A;
            w.seq_ld = 1'b1;
            w.seq_val = SEQ_HALF_B;
            w.target = U_SEND;
         end
         U_HALF_B: begin
            w.op = OP_LOAD_B;
            w.seq_ld = 1'b1;
            w.seq_val = SEQ_FREE;
            w.target = U_SEND;
         end
         U_SEND: begin
            w.emit = EM_DATA;
            w.op = OP_SEND;
            w.br = BR_LOOP;
         end
         U_FREE: begin
            w.emit = EM_FREE;
            w.seq_ld = 1'b1;
            w.seq_val = SEQ_IDLE;
         end
         U_SCAN: begin
            w.emit = EM_STATUS;
            w.op = OP_SCAN;
         end
         default: begin
            w.br = BR_GOTO;
         end
      endcase
      return w;
   endfunction

   // Entry step of a refresh step item, by sequencer state.
   function automatic logic [3:0] dispatch(input logic [2:0] seq);
      logic [3:0] u;
      case (seq)
         SEQ_LOW:    u = U_CMD_LOW;
         SEQ_HIGH:   u = U_CMD_HIGH;
         SEQ_PAGE:   u = U_CMD_PAGE;
         SEQ_HALF_A: u = U_HALF_A;
         SEQ_HALF_B: u = U_HALF_B;
         SEQ_FREE:   u = U_FREE;
         default:    u = U_SCAN;
      endcase
      return u;
   endfunction

endpackage

@@ rtl/ddlr_sequencer.sv @@
// ----------------------------------------------------------------------------
// ddlr_sequencer
// Step counter and program table; decides when a step completes and where next.
// ----------------------------------------------------------------------------
module ddlr_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_action,
   output logic               req_stall,
   input  ddlr_pkg::stat_type stat,
   output ddlr_pkg::ctrl_type ctrl
);

   logic [3:0]           upc_ff;
   logic [3:0]           upc_in;
   ddlr_pkg::uword_type  word;
   logic                 accept;
   logic                 fire;

   assign word      = ddlr_pkg::ucode(upc_ff);
   assign req_stall = !word.take;
   assign accept    = word.take && req_valid;

   always_comb begin
      if (word.br == ddlr_pkg::BR_DISPATCH) begin
         fire = accept;
      end else if (word.emit != ddlr_pkg::EM_NONE) begin
         fire = stat.out_free;
      end else begin
         fire = 1'b1;
      end
   end

   always_comb begin
      upc_in = upc_ff;
      case (word.br)
         ddlr_pkg::BR_GOTO: begin
            if (fire) upc_in = word.target;
         end
         ddlr_pkg::BR_LOOP: begin
            if (fire && stat.done) upc_in = word.target;
         end
         ddlr_pkg::BR_COND: begin
            if (fire) upc_in = stat.done ? word.target : upc_ff + 4'd1;
         end
         ddlr_pkg::BR_DISPATCH: begin
            if (accept) begin
               upc_in = req_action ? ddlr_pkg::U_FILL_SETUP
                                   : ddlr_pkg::dispatch(stat.seq_state);
            end
         end
         default: upc_in = ddlr_pkg::U_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= ddlr_pkg::U_CLEAR;
      end else begin
         upc_ff <= upc_in;
      end
   end

   assign ctrl.word = word;
   assign ctrl.fire = fire;

endmodule

@@ rtl/ddlr_datapath.sv @@
// ----------------------------------------------------------------------------
// ddlr_datapath
// Line store, dirty flags, scan pointer, column counters and result register.
// ----------------------------------------------------------------------------
module ddlr_datapath #(
   parameter int LINE_WIDTH = 128,
   parameter int NUM_LINES  = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  ddlr_pkg::ctrl_type ctrl,
   input  ddlr_pkg::cfg_type  cfg,
   input  logic [2:0]         req_line_index,
   input  logic [6:0]         req_start_col,
   input  logic [7:0]         req_fill_value,
   input  logic [7:0]         req_run_length,
   output ddlr_pkg::stat_type stat,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_transfer_start,
   output logic               rsp_last,
   output logic               rsp_bus_free
);

   localparam int DEPTH     = NUM_LINES * LINE_WIDTH;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int COL_W     = $clog2(LINE_WIDTH);
   localparam int LINE_BITS = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
   localparam int HALF      = LINE_WIDTH / 2;

   logic [7:0]           mem [DEPTH];

   logic [2:0]           ln_ff;
   logic [6:0]           start_ff;
   logic [7:0]           val_ff;
   logic [7:0]           run_ff;
   logic [COL_W-1:0]     col_ff;
   logic [7:0]           cnt_ff;
   logic [COL_W:0]       to_ff;
   logic                 first_ff;
   logic [7:0]           rd_ff;
   logic [ADDR_W-1:0]    clr_ff;
   logic [2:0]           seq_ff;
   logic [2:0]           scan_ff;
   logic [NUM_LINES-1:0] dirty_ff;
   logic                 rsp_valid_ff;
   logic [1:0]           kind_ff;
   logic [7:0]           byte_ff;
   logic                 start_out_ff;
   logic                 last_ff;
   logic                 free_ff;

   logic [2:0]           op;
   logic [2:0]           emit;
   logic                 fire;
   logic                 line_ok;
   logic                 col_ok;
   logic [7:0]           room;
   logic [7:0]           fill_n;
   logic                 fill_skip;
   logic [COL_W-1:0]     col_nx;
   logic                 col_end;
   logic [3:0]           scan_inc;
   logic [3:0]           scan_nx;
   logic                 hit;
   logic                 done;
   logic                 we;
   logic                 re;
   logic [ADDR_W-1:0]    waddr;
   logic [7:0]           wdata;
   logic [COL_W-1:0]     rcol;
   logic [ADDR_W-1:0]    raddr;
   logic [ADDR_W-1:0]    fill_addr;

   assign op   = ctrl.word.op;
   assign emit = ctrl.word.emit;
   assign fire = ctrl.fire;

   // Fill run bounds: clip at the line end, drop lines outside the store.
   assign line_ok   = {1'b0, ln_ff} < 4'(NUM_LINES);
   assign col_ok    = {1'b0, start_ff} < 8'(LINE_WIDTH);
   assign room      = 8'(LINE_WIDTH) - {1'b0, start_ff};
   assign fill_n    = (run_ff < room) ? run_ff : room;
   assign fill_skip = !line_ok || !col_ok || (fill_n == 8'd0);

   assign col_nx  = col_ff + COL_W'(1);
   assign col_end = ({1'b0, col_ff} + (COL_W + 1)'(1)) == to_ff;

   // Round-robin pointer wraps at the configured line count or at eight.
   assign scan_inc = {1'b0, scan_ff} + 4'd1;
   assign scan_nx  = (scan_inc >= cfg.buffer_lines || scan_inc >= 4'd8) ? 4'd0 : scan_inc;
   assign hit      = (scan_nx < 4'(NUM_LINES)) && (scan_nx < cfg.buffer_lines)
                     && dirty_ff[scan_nx[LINE_BITS-1:0]];

   always_comb begin
      case (op)
         ddlr_pkg::OP_CLEAR:      done = clr_ff == ADDR_W'(DEPTH - 1);
         ddlr_pkg::OP_FILL_SETUP: done = fill_skip;
         ddlr_pkg::OP_FILL_WRITE: done = cnt_ff == 8'd1;
         ddlr_pkg::OP_SEND:       done = col_end;
         default:                 done = 1'b0;
      endcase
   end

   assign fill_addr = ADDR_W'(ADDR_W'(ln_ff[LINE_BITS-1:0]) * ADDR_W'(LINE_WIDTH))
                      + ADDR_W'(col_ff);

   assign we    = fire && (op == ddlr_pkg::OP_CLEAR || op == ddlr_pkg::OP_FILL_WRITE);
   assign waddr = (op == ddlr_pkg::OP_CLEAR) ? clr_ff : fill_addr;
   assign wdata = (op == ddlr_pkg::OP_CLEAR) ? 8'h00 : val_ff;

   // Next byte read as this one leaves: one byte per cycle while the output is free.
   assign re = fire && (op == ddlr_pkg::OP_LOAD_A || op == ddlr_pkg::OP_LOAD_B
                        || (op == ddlr_pkg::OP_SEND && !col_end));

   always_comb begin
      case (op)
         ddlr_pkg::OP_LOAD_A: rcol = '0;
         ddlr_pkg::OP_LOAD_B: rcol = COL_W'(HALF);
         default:             rcol = col_nx;
      endcase
   end

   assign raddr = ADDR_W'(ADDR_W'(scan_ff[LINE_BITS-1:0]) * ADDR_W'(LINE_WIDTH))
                  + ADDR_W'(rcol);

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rd_ff <= mem[raddr];
      end
   end

   // Captured fields of the accepted beat.
   always_ff @(posedge clock) begin
      if (ctrl.word.take && fire) begin
         ln_ff    <= req_line_index;
         start_ff <= req_start_col;
         val_ff   <= req_fill_value;
         run_ff   <= req_run_length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         cnt_ff   <= '0;
         to_ff    <= '0;
         first_ff <= 1'b0;
         clr_ff   <= '0;
         seq_ff   <= ddlr_pkg::SEQ_IDLE;
         scan_ff  <= '0;
         dirty_ff <= '1;
      end else if (fire) begin
         case (op)
            ddlr_pkg::OP_CLEAR: begin
               clr_ff <= clr_ff + ADDR_W'(1);
            end
            ddlr_pkg::OP_FILL_SETUP: begin
               if (line_ok) dirty_ff[ln_ff[LINE_BITS-1:0]] <= 1'b1;
               col_ff <= COL_W'(start_ff);
               cnt_ff <= fill_n;
            end
            ddlr_pkg::OP_FILL_WRITE: begin
               col_ff <= col_nx;
               cnt_ff <= cnt_ff - 8'd1;
            end
            ddlr_pkg::OP_LOAD_A: begin
               col_ff   <= '0;
               to_ff    <= (COL_W + 1)'(HALF);
               first_ff <= 1'b1;
            end
            ddlr_pkg::OP_LOAD_B: begin
               col_ff   <= COL_W'(HALF);
               to_ff    <= (COL_W + 1)'(LINE_WIDTH);
               first_ff <= 1'b1;
            end
            ddlr_pkg::OP_SEND: begin
               col_ff   <= col_nx;
               first_ff <= 1'b0;
            end
            ddlr_pkg::OP_SCAN: begin
               scan_ff <= scan_nx[2:0];
               if (hit) begin
                  dirty_ff[scan_nx[LINE_BITS-1:0]] <= 1'b0;
                  seq_ff <= ddlr_pkg::SEQ_LOW;
               end else begin
                  seq_ff <= ddlr_pkg::SEQ_IDLE;
               end
            end
            default: begin
            end
         endcase
         if (ctrl.word.seq_ld) begin
            seq_ff <= ctrl.word.seq_val;
         end
      end
   end

   // Result register: a beat waits here while the input side goes on.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && emit != ddlr_pkg::EM_NONE) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit != ddlr_pkg::EM_NONE) begin
         case (emit)
            ddlr_pkg::EM_LOW: begin
               kind_ff      <= ddlr_pkg::KIND_CMD;
               byte_ff      <= ddlr_pkg::CMD_LOW_COL + {4'd0, cfg.column_offset};
               start_out_ff <= 1'b1;
               last_ff      <= 1'b1;
               free_ff      <= 1'b0;
            end
            ddlr_pkg::EM_HIGH: begin
               kind_ff      <= ddlr_pkg::KIND_CMD;
               byte_ff      <= ddlr_pkg::CMD_HIGH_COL;
               start_out_ff <= 1'b1;
               last_ff      <= 1'b1;
               free_ff      <= 1'b0;
            end
            ddlr_pkg::EM_PAGE: begin
               kind_ff      <= ddlr_pkg::KIND_CMD;
               byte_ff      <= ddlr_pkg::CMD_PAGE + {5'd0, scan_ff};
               start_out_ff <= 1'b1;
               last_ff      <= 1'b1;
               free_ff      <= 1'b0;
            end
            ddlr_pkg::EM_DATA: begin
               kind_ff      <= ddlr_pkg::KIND_DATA;
               byte_ff      <= rd_ff;
               start_out_ff <= first_ff;
               last_ff      <= col_end;
               free_ff      <= 1'b0;
            end
            ddlr_pkg::EM_FREE: begin
               kind_ff      <= ddlr_pkg::KIND_STATUS;
               byte_ff      <= 8'h00;
               start_out_ff <= 1'b0;
               last_ff      <= 1'b1;
               free_ff      <= 1'b1;
            end
            default: begin
               kind_ff      <= ddlr_pkg::KIND_STATUS;
               byte_ff      <= 8'h00;
               start_out_ff <= 1'b0;
               last_ff      <= 1'b1;
               free_ff      <= 1'b0;
            end
         endcase
      end
   end

   assign stat.done      = done;
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;
   assign stat.seq_state = seq_ff;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_out_byte       = byte_ff;
   assign rsp_transfer_start = start_out_ff;
   assign rsp_last           = last_ff;
   assign rsp_bus_free       = free_ff;

endmodule

@@ rtl/display_dirty_line_refresh.sv @@
// ----------------------------------------------------------------------------
// display_dirty_line_refresh
// Dirty-line display refresh engine with a microprogrammed controller.
// ----------------------------------------------------------------------------
// After reset the engine sweeps the line store to zero, one byte per cycle, and
// holds req_stall high until it is done; configuration writes are taken
// throughout. A fill beat then passes a setup step, which clips the run and
// marks the line dirty, and a write step repeated for each byte written. A
// step beat gives a single command or status, or a half-line of data, which
// the single read port of the line store streams one byte per cycle while the
// output is free. Results wait in an output register, so a stall on the result
// side only holds the controller when it has a new result to place.
// ----------------------------------------------------------------------------
module display_dirty_line_refresh #(
   parameter int LINE_WIDTH = 128,
   parameter int NUM_LINES  = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [3:0] csr_wdata,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_action,
   input  logic [2:0] req_line_index,
   input  logic [6:0] req_start_col,
   input  logic [7:0] req_fill_value,
   input  logic [7:0] req_run_length,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_transfer_start,
   output logic       rsp_last,
   output logic       rsp_bus_free
);

   ddlr_pkg::cfg_type  cfg_ff;
   ddlr_pkg::ctrl_type ctrl;
   ddlr_pkg::stat_type stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.buffer_lines  <= 4'd8;
         cfg_ff.column_offset <= 4'd0;
      end else if (csr_we) begin
         case (csr_index)
            ddlr_pkg::CSR_BUFFER_LINES:  cfg_ff.buffer_lines  <= csr_wdata;
            ddlr_pkg::CSR_COLUMN_OFFSET: cfg_ff.column_offset <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   ddlr_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .stat       (stat),
      .ctrl       (ctrl)
   );

   ddlr_datapath #(
      .LINE_WIDTH (LINE_WIDTH),
      .NUM_LINES  (NUM_LINES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .cfg                (cfg_ff),
      .req_line_index     (req_line_index),
      .req_start_col      (req_start_col),
      .req_fill_value     (req_fill_value),
      .req_run_length     (req_run_length),
      .stat               (stat),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_transfer_start (rsp_transfer_start),
      .rsp_last           (rsp_last),
      .rsp_bus_free       (rsp_bus_free)
   );

endmodule

@@ rtl/ddlr_checker.sv @@
// ----------------------------------------------------------------------------
// ddlr_checker
// Port-level checks of the refresh engine, bound to the top level.
// ----------------------------------------------------------------------------
module ddlr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_transfer_start,
   input logic       rsp_last,
   input logic       rsp_bus_free
);

   // A stalled result beat stays and keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_out_byte) && $stable(rsp_last) && $stable(rsp_bus_free))
      else $error("result beat changed while stalled");

   // The store is being cleared right after reset, so no item may enter.
   a_clear_stall: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("input open or result shown during store clear");

   // Status beats carry no byte and close the item.
   a_status_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == ddlr_pkg::KIND_STATUS
         |-> rsp_last && !rsp_transfer_start && rsp_out_byte == 8'h00)
      else $error("malformed status beat");

   // Every command is a transaction of its own.
   a_cmd_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == ddlr_pkg::KIND_CMD
         |-> rsp_transfer_start && rsp_last && !rsp_bus_free)
      else $error("malformed command beat");

   // The bus is only released by a status beat.
   a_free_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bus_free |-> rsp_kind == ddlr_pkg::KIND_STATUS)
      else $error("bus released by a non-status beat");

endmodule

bind display_dirty_line_refresh ddlr_checker u_ddlr_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_kind           (rsp_kind),
   .rsp_out_byte       (rsp_out_byte),
   .rsp_transfer_start (rsp_transfer_start),
   .rsp_last           (rsp_last),
   .rsp_bus_free       (rsp_bus_free)
);
